// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, constants and address helpers for the text console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int unsigned MAX_COLS   = 80;
  localparam int unsigned MAX_ROWS   = 25;
  localparam int unsigned LINE_BYTES = 128;
  localparam int unsigned STORE_ROWS = 32;

  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned BYTE_W = 8;

  localparam int unsigned DEPTH  = STORE_ROWS * LINE_BYTES;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  localparam int unsigned COL_CAP =
      (MAX_COLS < LINE_BYTES - 2) ? MAX_COLS : LINE_BYTES - 2;
  localparam int unsigned ROW_CAP =
      (MAX_ROWS < STORE_ROWS - 1) ? MAX_ROWS : STORE_ROWS - 1;

  localparam logic [COL_W-1:0]  RST_LAST_COL = COL_W'(79);
  localparam logic [ROW_W-1:0]  RST_LAST_ROW = ROW_W'(24);

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'd10;

  // register select, paddr bit 2
  localparam logic REG_LAST_COL = 1'b0;
  localparam logic REG_LAST_ROW = 1'b1;

  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_RDW,
    ST_WR0,
    ST_WR1,
    ST_CLR,
    ST_SCP,
    ST_SDR,
    ST_SZR
  } state_e;

  function automatic logic in_store(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
    return (int'(r) < STORE_ROWS) && (int'(c) < LINE_BYTES);
  endfunction

  function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] r);
    return ADDR_W'(int'(r) * LINE_BYTES);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(int'(r) * LINE_BYTES + int'(c));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Text console over a byte-wide screen memory: put char, move cursor,
// clear screen, read cell; a line feed or a wrap on the last row scrolls the screen.
// ----------------------------------------------------------------------------
// move, CR and a plain LF finish without raising busy; read cell, a stored char, clear
// and scroll hold busy until done. last_row is clamped to 25. Clear zeroes the first
// byte of each row 0..last_row. A scroll copies rows 1..last_row up one row, then
// zeroes the last row, one byte per write cycle. A new item is taken only when the
// last one is done. done is a one-cycle strobe, no back-pressure. After reset busy
// stays high while screen memory is zeroed; register writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire  [1:0]                   kind_i,
  input  wire  [tcw_pkg::BYTE_W-1:0]   char_code_i,
  input  wire  [tcw_pkg::COL_W-1:0]    column_i,
  input  wire  [tcw_pkg::ROW_W-1:0]    row_i,
  output logic                         done_o,
  output logic [tcw_pkg::COL_W-1:0]    cursor_column_o,
  output logic [tcw_pkg::ROW_W-1:0]    cursor_row_o,
  output logic [tcw_pkg::BYTE_W-1:0]   cell_byte_o,
  input  wire                          psel_i,
  input  wire                          penable_i,
  input  wire                          pwrite_i,
  input  wire  [2:0]                   paddr_i,
  input  wire  [31:0]                  pwdata_i,
  output logic [31:0]                  prdata_o,
  output logic                         pready_o
);
  import tcw_pkg::*;

  localparam logic [ADDR_W-1:0] LB_STEP   = ADDR_W'(LINE_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [COL_W-1:0]    cursor_col_q, cursor_col_d;
  logic [ROW_W-1:0]    cursor_line_q, cursor_line_d;
  logic [COL_W-1:0]    last_col_q;
  logic [ROW_W-1:0]    last_row_q;
  logic                done_q, done_d;
  logic                cp_wr_q, cp_wr_d;
  logic [ADDR_W-1:0]   cp_waddr_q, cp_waddr_d;
  logic                wr_pend_q, wr_pend_d;
  logic [BYTE_W-1:0]   char_q, char_d;
  logic [BYTE_W-1:0]   cell_q, cell_d;
  logic                rd_in_q, rd_in_d;

  logic [BYTE_W-1:0]   screen_mem_q [DEPTH];
  logic [BYTE_W-1:0]   rd_data_q;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [BYTE_W-1:0]   mem_wdata;

  logic [COL_W-1:0]    eff_col;
  logic [ROW_W-1:0]    eff_row;
  logic [ADDR_W-1:0]   row_end;
  logic [COL_W-1:0]    col_p1;
  logic                accept, is_cr, is_lf, need_wrap, at_last;
  kind_e               kind;
  logic                cfg_wr;

  assign kind      = kind_e'(kind_i);
  assign accept    = start_i && (state_q == ST_IDLE);
  assign eff_col   = (int'(last_col_q) > COL_CAP) ? COL_W'(COL_CAP) : last_col_q;
  assign eff_row   = (int'(last_row_q) > ROW_CAP) ? ROW_W'(ROW_CAP) : last_row_q;
  assign row_end   = row_base(eff_row) + LB_STEP - ADDR_W'(1);
  assign col_p1    = cursor_col_q + COL_W'(1);
  assign is_cr     = (char_code_i == CHAR_CR);
  assign is_lf     = (char_code_i == CHAR_LF);
  assign need_wrap = (cursor_col_q >= eff_col);
  assign at_last   = (cursor_line_q >= eff_row);

  // configuration port
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_comb begin
    prdata_o = '0;
    unique case (paddr_i[2])
      REG_LAST_COL: prdata_o = 32'(last_col_q);
      REG_LAST_ROW: prdata_o = 32'(last_row_q);
      default:      prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= RST_LAST_COL;
      last_row_q <= RST_LAST_ROW;
    end else if (cfg_wr) begin
      unique case (paddr_i[2])
        REG_LAST_COL: last_col_q <= pwdata_i[COL_W-1:0];
        REG_LAST_ROW: last_row_q <= pwdata_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: if (addr_q == LAST_ADDR) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_PUT: begin
              if (is_cr) begin
                state_d = ST_IDLE;
              end else if (is_lf && !at_last) begin
                state_d = ST_IDLE;
              end else if (!is_lf && (!need_wrap || !at_last)) begin
                state_d = ST_WR0;
              end else begin
                state_d = (eff_row == '0) ? ST_SZR : ST_SCP;
              end
            end
            KIND_MOVE:  state_d = ST_IDLE;
            KIND_CLEAR: state_d = ST_CLR;
            default:    state_d = ST_RDW;
          endcase
        end
      end
      ST_RDW: state_d = ST_IDLE;
      ST_WR0: state_d = ST_WR1;
      ST_WR1: state_d = ST_IDLE;
      ST_CLR: if (addr_q == row_base(eff_row)) state_d = ST_IDLE;
      ST_SCP: if (addr_q == row_end) state_d = ST_SDR;
      ST_SDR: state_d = ST_SZR;
      ST_SZR: if (addr_q == row_end) state_d = wr_pend_q ? ST_WR0 : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    addr_d        = addr_q;
    cursor_col_d  = cursor_col_q;
    cursor_line_d = cursor_line_q;
    done_d        = 1'b0;
    cp_wr_d       = 1'b0;
    cp_waddr_d    = cp_waddr_q;
    wr_pend_d     = wr_pend_q;
    char_d        = char_q;
    cell_d        = '0;
    rd_in_d       = rd_in_q;
    mem_we        = 1'b0;
    mem_waddr     = addr_q;
    mem_wdata     = '0;
    mem_raddr     = addr_q;
    unique case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        addr_d = addr_q + ADDR_W'(1);
      end
      ST_IDLE: begin
        mem_raddr = cell_addr(row_i, column_i);
        if (accept) begin
          char_d  = char_code_i;
          rd_in_d = in_store(row_i, column_i);
          case (kind)
            KIND_PUT: begin
              if (is_cr) begin
                cursor_col_d = '0;
                done_d       = 1'b1;
              end else begin
                if (!is_lf && need_wrap) cursor_col_d = '0;
                if (is_lf || need_wrap) begin
                  if (!at_last) begin
                    cursor_line_d = cursor_line_q + ROW_W'(1);
                    done_d        = is_lf;
                  end else begin
                    wr_pend_d = !is_lf;
                    addr_d    = (eff_row == '0) ? '0 : LB_STEP;
                  end
                end
              end
            end
            KIND_MOVE: begin
              cursor_col_d  = column_i;
              cursor_line_d = row_i;
              done_d        = 1'b1;
            end
            KIND_CLEAR: addr_d = '0;
            default: ;
          endcase
        end
      end
      ST_RDW: begin
        cell_d = rd_in_q ? rd_data_q : '0;
        done_d = 1'b1;
      end
      ST_WR0: begin
        mem_we    = in_store(cursor_line_q, cursor_col_q);
        mem_waddr = cell_addr(cursor_line_q, cursor_col_q);
        mem_wdata = char_q;
      end
      ST_WR1: begin
        mem_we       = in_store(cursor_line_q, col_p1);
        mem_waddr    = cell_addr(cursor_line_q, col_p1);
        cursor_col_d = col_p1;
        done_d       = 1'b1;
      end
      ST_CLR: begin
        mem_we = 1'b1;
        addr_d = addr_q + LB_STEP;
        done_d = (addr_q == row_base(eff_row));
      end
      ST_SCP: begin
        cp_wr_d    = 1'b1;
        cp_waddr_d = addr_q - LB_STEP;
        addr_d     = addr_q + ADDR_W'(1);
      end
      ST_SDR: addr_d = row_base(eff_row);
      ST_SZR: begin
        mem_we = 1'b1;
        addr_d = addr_q + ADDR_W'(1);
        if (addr_q == row_end) begin
          done_d    = !wr_pend_q;
          wr_pend_d = 1'b0;
        end
      end
      default: ;
    endcase
    // copy beat of a scroll, in the cycle after its read
    if (cp_wr_q) begin
      mem_we    = 1'b1;
      mem_waddr = cp_waddr_q;
      mem_wdata = rd_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_INIT;
      addr_q        <= '0;
      cursor_col_q  <= '0;
      cursor_line_q <= '0;
      done_q        <= 1'b0;
      cp_wr_q       <= 1'b0;
      wr_pend_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      addr_q        <= addr_d;
      cursor_col_q  <= cursor_col_d;
      cursor_line_q <= cursor_line_d;
      done_q        <= done_d;
      cp_wr_q       <= cp_wr_d;
      wr_pend_q     <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_waddr_q <= cp_waddr_d;
    char_q     <= char_d;
    cell_q     <= cell_d;
    rd_in_q    <= rd_in_d;
  end

  // screen memory
  always_ff @(posedge clk_i) begin
    if (mem_we) screen_mem_q[mem_waddr] <= mem_wdata;
    rd_data_q <= screen_mem_q[mem_raddr];
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign cursor_column_o = cursor_col_q;
  assign cursor_row_o    = cursor_line_q;
  assign cell_byte_o     = cell_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("done strobe while busy");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("screen write while idle");

  a_copy_in_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_wr_q |-> (state_q == ST_SCP || state_q == ST_SDR))
    else $error("copy beat outside scroll");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted item neither busy nor done");

endmodule

`default_nettype wire
